// ----- sv/dsf_pkg.sv -----
// Package for the deadzone smooth-damp 2D follower.
// Holds the fixed-point constants, register codes, request types and saturation helpers.
// No dependencies.
package dsf_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [30:0] ST_RESET = 31'd19661;
	localparam logic [30:0] ST_MIN   = 31'd7;
	localparam logic [15:0] K_048    = 16'd31457;
	localparam logic [15:0] K_0235   = 16'd15401;
	localparam logic [26:0] X_CAP    = 27'h400_0000;
	localparam logic [47:0] ONE_Q    = 48'd1 << FRAC_BITS;

	localparam logic [2:0] REG_DZ_X   = 3'd0;
	localparam logic [2:0] REG_DZ_Y   = 3'd1;
	localparam logic [2:0] REG_SMOOTH = 3'd2;
	localparam logic [2:0] REG_SPEED  = 3'd3;
	localparam logic [2:0] REG_MIN_X  = 3'd4;
	localparam logic [2:0] REG_MAX_X  = 3'd5;
	localparam logic [2:0] REG_MIN_Y  = 3'd6;
	localparam logic [2:0] REG_MAX_Y  = 3'd7;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic [15:0]        time_step;
	} dsf_in_t;

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
	} dsf_out_t;

	typedef struct packed {
		logic        snap;
		logic        limited;
		logic [15:0] ts;
		logic [30:0] omega;
		logic [16:0] ex;
		logic [46:0] maxch;
	} dsf_prm_t;

	function automatic logic signed [47:0] sat46(input logic signed [48:0] v);
		logic signed [48:0] lim;
		lim = 49'sh0_4000_0000_0000;
		if (v > lim)
			return 48'sh4000_0000_0000;
		else if (v < -lim)
			return -48'sh4000_0000_0000;
		else
			return v[47:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -48'sh0000_8000_0000)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

// ----- sv/dsf_mul.sv -----
// Serial Q.F multiplier: sign(a*b) * (|a|*|b| >> FRAC_BITS), operands and result saturated at 2^46.
// Takes b in three 16-bit chunks, top first, one per cycle. Uses dsf_pkg.
module dsf_mul import dsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] a,
	input  logic signed [47:0] b,
	output logic               done,
	output logic signed [47:0] res
);

	logic        busy_q;
	logic        done_q;
	logic [1:0]  cnt_q;
	logic [46:0] am_q;
	logic [46:0] bm_q;
	logic        neg_q;
	logic        sat_q;
	logic [63:0] acc_q;
	logic [15:0] chunk;
	logic [62:0] prod;
	logic [64:0] nacc;
	logic        over;
	logic [46:0] mag_r;

	function automatic logic [46:0] mag(input logic signed [47:0] v);
		logic [47:0] av;
		av = v[47] ? 48'(-v) : 48'(v);
		if (av > 48'h4000_0000_0000)
			return 47'h4000_0000_0000;
		else
			return av[46:0];
	endfunction

	always_comb begin
		case (cnt_q)
			2'd0:    chunk = {1'b0, bm_q[46:32]};
			2'd1:    chunk = bm_q[31:16];
			default: chunk = bm_q[15:0];
		endcase
		prod = 63'(am_q) * 63'(chunk);
		nacc = {2'b0, acc_q[46:0], 16'b0} + {2'b0, prod};
		case (cnt_q)
			2'd0:    over = nacc > 65'h4000_0000;
			2'd1:    over = nacc > 65'h4000_0000_0000;
			default: over = nacc[64:16] > 49'h4000_0000_0000;
		endcase
		mag_r = (sat_q || over) ? 47'h4000_0000_0000 : nacc[62:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= mag(a);
			bm_q  <= mag(b);
			neg_q <= a[47] ^ b[47];
			acc_q <= 64'd0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			acc_q <= nacc[63:0];
			sat_q <= sat_q | over;
			if (cnt_q == 2'd2)
				res <= neg_q ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
		end
	end

	assign done = done_q;

endmodule

// ----- sv/dsf_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient up to 31 bits.
// The caller gives the top quotient bit position; the quotient must fit below it. Uses dsf_pkg.
module dsf_div import dsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] num,
	input  logic [47:0] den,
	input  logic [4:0]  sh,
	output logic        done,
	output logic [30:0] quo
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [33:0] rem_q;
	logic [63:0] dsh_q;
	logic [30:0] quo_q;
	logic        ge;

	assign ge = {30'b0, rem_q} >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= sh;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {16'b0, den} << sh;
			quo_q <= 31'd0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q[33:0];
			quo_q <= {quo_q[29:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- sv/dsf_lane.sv -----
// One axis lane: deadzone, smooth-damp step, overshoot guard and bounds clamp.
// Holds the axis position and velocity; uses dsf_mul and dsf_pkg.
module dsf_lane import dsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  dsf_prm_t           prm,
	input  logic signed [31:0] tgt,
	input  logic [30:0]        half,
	input  logic signed [31:0] bmin,
	input  logic signed [31:0] bmax,
	output logic               done,
	output logic signed [31:0] pos
);

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_M1   = 3'd1;
	localparam logic [2:0] L_M2   = 3'd2;
	localparam logic [2:0] L_M3   = 3'd3;
	localparam logic [2:0] L_M4   = 3'd4;
	localparam logic [2:0] L_M5   = 3'd5;

	logic [2:0]         st_q;
	logic               go_q;
	logic               done_q;
	logic signed [31:0] pos_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] des_q;
	logic signed [32:0] chg_q;
	logic signed [47:0] temp_q;
	logic signed [47:0] nv_q;

	logic signed [32:0] d;
	logic signed [32:0] hx;
	logic signed [31:0] des_c;
	logic signed [32:0] chg_raw;
	logic signed [47:0] chg48;
	logic signed [47:0] mc48;
	logic signed [32:0] chg_c;
	logic signed [47:0] ma;
	logic signed [47:0] mb;
	logic               mdone;
	logic signed [47:0] mres;
	logic signed [48:0] outp;
	logic               guard;
	logic signed [31:0] new_pos;

	function automatic logic signed [31:0] bnd(input logic signed [31:0] p,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		if (lo <= hi) begin
			if (p < lo)
				return lo;
			if (p > hi)
				return hi;
		end
		return p;
	endfunction

	always_comb begin
		d       = 33'(tgt) - 33'(pos_q);
		hx      = {2'b0, half};
		if (d > hx)
			des_c = 32'(33'(tgt) - hx);
		else if (d < -hx)
			des_c = 32'(33'(tgt) + hx);
		else
			des_c = pos_q;
		chg_raw = 33'(pos_q) - 33'(des_c);
		chg48   = 48'(chg_raw);
		mc48    = $signed({1'b0, prm.maxch});
		chg_c   = chg_raw;
		if (prm.limited) begin
			if (chg48 > mc48)
				chg_c = 33'(mc48);
			else if (chg48 < -mc48)
				chg_c = 33'(-mc48);
		end

		case (st_q)
			L_M1: begin
				ma = $signed({17'b0, prm.omega});
				mb = 48'(chg_q);
			end
			L_M2: begin
				ma = sat46(49'(vel_q) + 49'(mres));
				mb = $signed({32'b0, prm.ts});
			end
			L_M3: begin
				ma = $signed({17'b0, prm.omega});
				mb = temp_q;
			end
			L_M4: begin
				ma = sat46(49'(vel_q) - 49'(mres));
				mb = $signed({31'b0, prm.ex});
			end
			default: begin
				ma = sat46(49'(chg_q) + 49'(temp_q));
				mb = $signed({31'b0, prm.ex});
			end
		endcase

		outp    = 49'(pos_q) - 49'(chg_q) + 49'(mres);
		guard   = (des_q > pos_q) == (outp > 49'(des_q));
		new_pos = guard ? des_q : sat32(outp[47:0]);
	end

	dsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.a      (ma),
		.b      (mb),
		.done   (mdone),
		.res    (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			go_q   <= 1'b0;
			done_q <= 1'b0;
			pos_q  <= 32'sd0;
			vel_q  <= 32'sd0;
		end else begin
			done_q <= 1'b0;
			go_q   <= 1'b0;
			case (st_q)
				L_IDLE: begin
					if (start) begin
						if (prm.snap) begin
							pos_q  <= bnd(des_c, bmin, bmax);
							vel_q  <= 32'sd0;
							done_q <= 1'b1;
						end else begin
							st_q <= L_M1;
							go_q <= 1'b1;
						end
					end
				end
				L_M1, L_M2, L_M3, L_M4: begin
					if (mdone) begin
						st_q <= st_q + 3'd1;
						go_q <= 1'b1;
					end
				end
				L_M5: begin
					if (mdone) begin
						pos_q  <= bnd(new_pos, bmin, bmax);
						vel_q  <= guard ? 32'sd0 : sat32(nv_q);
						done_q <= 1'b1;
						st_q   <= L_IDLE;
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == L_IDLE && start) begin
			des_q <= des_c;
			chg_q <= chg_c;
		end
		if (mdone && st_q == L_M2)
			temp_q <= mres;
		if (mdone && st_q == L_M4)
			nv_q <= mres;
	end

	assign done = done_q;
	assign pos  = pos_q;

endmodule

// ----- sv/deadzone_smoothdamp_follow_2d.sv -----
// Top level of the deadzone smooth-damp 2D follower; uses dsf_pkg, dsf_div, dsf_mul, dsf_lane.
// A zero time step goes straight to the output, a zero smooth_time goes straight to the lanes,
// and otherwise the request runs through the shared divider and the serial multipliers.
// One request in flight; the next is taken as soon as the result is registered.
// Reset clears position, velocity and control state and loads the register defaults.
module deadzone_smoothdamp_follow_2d import dsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  dsf_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output dsf_out_t    out_data,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DIV_OM = 4'd1;
	localparam logic [3:0] S_MUL_X  = 4'd2;
	localparam logic [3:0] S_MUL_X2 = 4'd3;
	localparam logic [3:0] S_MUL_X3 = 4'd4;
	localparam logic [3:0] S_MUL_T1 = 4'd5;
	localparam logic [3:0] S_MUL_T2 = 4'd6;
	localparam logic [3:0] S_MUL_MC = 4'd7;
	localparam logic [3:0] S_DIV_EX = 4'd8;
	localparam logic [3:0] S_LANE   = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	localparam logic [33:0] NUM_OM = 34'd1 << (2 * FRAC_BITS + 1);
	localparam logic [33:0] NUM_EX = 34'd1 << (2 * FRAC_BITS);
	localparam logic [4:0]  SH_OM  = 5'd30;
	localparam logic [4:0]  SH_EX  = 5'd16;

	logic [30:0]        dz_x_q;
	logic [30:0]        dz_y_q;
	logic [30:0]        smooth_q;
	logic [30:0]        speed_q;
	logic signed [31:0] min_x_q;
	logic signed [31:0] max_x_q;
	logic signed [31:0] min_y_q;
	logic signed [31:0] max_y_q;

	logic [3:0]         st_q;
	logic               go_q;
	logic               dn_x_q;
	logic               dn_y_q;
	logic               out_valid_q;
	dsf_out_t           out_q;
	logic signed [31:0] tgt_x_q;
	logic signed [31:0] tgt_y_q;
	logic [15:0]        ts_q;
	logic [30:0]        omega_q;
	logic [26:0]        x_q;
	logic [36:0]        x2_q;
	logic [46:0]        x3_q;
	logic [46:0]        t1_q;
	logic [46:0]        t2_q;
	logic [46:0]        mc_q;
	logic [16:0]        ex_q;

	logic [30:0]        stf;
	logic [47:0]        den_c;
	logic               accept;
	logic               mul_go;
	logic               div_go;
	logic signed [47:0] ma;
	logic signed [47:0] mb;
	logic               mdone;
	logic signed [47:0] mres;
	logic [33:0]        dnum;
	logic [47:0]        dden;
	logic [4:0]         dsh;
	logic               div_done;
	logic [30:0]        quo;
	dsf_prm_t           prm;
	logic               lane_go;
	logic               ldone_x;
	logic               ldone_y;
	logic signed [31:0] lpos_x;
	logic signed [31:0] lpos_y;

	assign stf    = (smooth_q < ST_MIN) ? ST_MIN : smooth_q;
	assign den_c  = ONE_Q + 48'(x_q) + 48'(t1_q) + 48'(t2_q);
	assign accept = in_valid && !in_stall;
	assign in_stall = st_q != S_IDLE;

	always_comb begin
		case (st_q)
			S_MUL_X: begin
				ma = $signed({17'b0, omega_q});
				mb = $signed({32'b0, ts_q});
			end
			S_MUL_X2: begin
				ma = $signed({21'b0, x_q});
				mb = $signed({21'b0, x_q});
			end
			S_MUL_X3: begin
				ma = $signed({11'b0, x2_q});
				mb = $signed({21'b0, x_q});
			end
			S_MUL_T1: begin
				ma = $signed({11'b0, x2_q});
				mb = $signed({32'b0, K_048});
			end
			S_MUL_T2: begin
				ma = $signed({1'b0, x3_q});
				mb = $signed({32'b0, K_0235});
			end
			default: begin
				ma = $signed({17'b0, speed_q});
				mb = $signed({17'b0, stf});
			end
		endcase
		if (st_q == S_DIV_OM) begin
			dnum = NUM_OM;
			dden = {17'b0, stf};
			dsh  = SH_OM;
		end else begin
			dnum = NUM_EX;
			dden = den_c;
			dsh  = SH_EX;
		end
		mul_go  = go_q && st_q >= S_MUL_X && st_q <= S_MUL_MC;
		div_go  = go_q && (st_q == S_DIV_OM || st_q == S_DIV_EX);
		lane_go = go_q && st_q == S_LANE;

		prm.snap    = smooth_q == 31'd0;
		prm.limited = speed_q != 31'd0;
		prm.ts      = ts_q;
		prm.omega   = omega_q;
		prm.ex      = ex_q;
		prm.maxch   = mc_q;
	end

	dsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (dnum),
		.den    (dden),
		.sh     (dsh),
		.done   (div_done),
		.quo    (quo)
	);

	dsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (ma),
		.b      (mb),
		.done   (mdone),
		.res    (mres)
	);

	dsf_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_go),
		.prm    (prm),
		.tgt    (tgt_x_q),
		.half   (dz_x_q),
		.bmin   (min_x_q),
		.bmax   (max_x_q),
		.done   (ldone_x),
		.pos    (lpos_x)
	);

	dsf_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_go),
		.prm    (prm),
		.tgt    (tgt_y_q),
		.half   (dz_y_q),
		.bmin   (min_y_q),
		.bmax   (max_y_q),
		.done   (ldone_y),
		.pos    (lpos_y)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_x_q   <= 31'd0;
			dz_y_q   <= 31'd0;
			smooth_q <= ST_RESET;
			speed_q  <= 31'd0;
			min_x_q  <= 32'sd65536;
			max_x_q  <= 32'sd0;
			min_y_q  <= 32'sd65536;
			max_y_q  <= 32'sd0;
		end else if (wr_en) begin
			case (wr_index)
				REG_DZ_X:   dz_x_q   <= wr_data[30:0];
				REG_DZ_Y:   dz_y_q   <= wr_data[30:0];
				REG_SMOOTH: smooth_q <= wr_data[30:0];
				REG_SPEED:  speed_q  <= wr_data[30:0];
				REG_MIN_X:  min_x_q  <= wr_data;
				REG_MAX_X:  max_x_q  <= wr_data;
				REG_MIN_Y:  min_y_q  <= wr_data;
				REG_MAX_Y:  max_y_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			go_q        <= 1'b0;
			dn_x_q      <= 1'b0;
			dn_y_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						go_q   <= 1'b1;
						dn_x_q <= 1'b0;
						dn_y_q <= 1'b0;
						if (in_data.time_step == 16'd0) begin
							st_q <= S_OUT;
							go_q <= 1'b0;
						end else if (smooth_q == 31'd0)
							st_q <= S_LANE;
						else
							st_q <= S_DIV_OM;
					end
				end
				S_DIV_OM, S_DIV_EX: begin
					if (div_done) begin
						st_q <= st_q + 4'd1;
						go_q <= 1'b1;
					end
				end
				S_MUL_X, S_MUL_X2, S_MUL_X3, S_MUL_T1, S_MUL_T2, S_MUL_MC: begin
					if (mdone) begin
						st_q <= st_q + 4'd1;
						go_q <= 1'b1;
					end
				end
				S_LANE: begin
					if (ldone_x)
						dn_x_q <= 1'b1;
					if (ldone_y)
						dn_y_q <= 1'b1;
					if ((dn_x_q || ldone_x) && (dn_y_q || ldone_y))
						st_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_x_q <= in_data.target_x;
			tgt_y_q <= in_data.target_y;
			ts_q    <= in_data.time_step;
		end
		if (st_q == S_DIV_OM && div_done)
			omega_q <= quo;
		if (st_q == S_DIV_EX && div_done)
			ex_q <= quo[16:0];
		if (mdone) begin
			case (st_q)
				S_MUL_X:  x_q  <= (mres > 48'(X_CAP)) ? X_CAP : mres[26:0];
				S_MUL_X2: x2_q <= mres[36:0];
				S_MUL_X3: x3_q <= mres[46:0];
				S_MUL_T1: t1_q <= mres[46:0];
				S_MUL_T2: t2_q <= mres[46:0];
				S_MUL_MC: mc_q <= mres[46:0];
				default: ;
			endcase
		end
		if (st_q == S_OUT && (!out_valid_q || !out_stall)) begin
			out_q.cam_x <= lpos_x;
			out_q.cam_y <= lpos_y;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> st_q != S_IDLE)
		else $error("accepted request left sequencer idle");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == S_OUT)
		else $error("result raised outside output state");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == S_DIV_OM || st_q == S_DIV_EX))
		else $error("divider finished outside a divide state");

	a_lane_state: assert property (@(posedge clk) disable iff (!arst_n)
		(ldone_x || ldone_y) |-> st_q == S_LANE)
		else $error("lane finished outside lane state");

endmodule

// ----- tb/follow_board.sv -----
`timescale 1ns / 100ps
// Scoreboard for the deadzone smooth-damp 2D follower: bit-exact follower predictor
// and queue of expected camera positions. Depends on dsf_pkg.
import dsf_pkg::*;

class follow_board;

	localparam longint SAT_LIM = 64'sd1 <<< 46;
	localparam longint unsigned FMASK = 64'hFFFF;

	int errors;
	dsf_out_t cam_expected[$];
	longint unsigned dz_x, dz_y, smooth, speed;
	longint min_x, max_x, min_y, max_y;
	longint px, py, vx, vy;

	function new();
		errors = 0;
		dz_x = 0; dz_y = 0; smooth = ST_RESET; speed = 0;
		min_x = 65536; max_x = 0; min_y = 65536; max_y = 0;
		px = 0; py = 0; vx = 0; vy = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] d);
		case (idx)
			REG_DZ_X:   dz_x = d[30:0];
			REG_DZ_Y:   dz_y = d[30:0];
			REG_SMOOTH: smooth = d[30:0];
			REG_SPEED:  speed = d[30:0];
			REG_MIN_X:  min_x = longint'($signed(d));
			REG_MAX_X:  max_x = longint'($signed(d));
			REG_MIN_Y:  min_y = longint'($signed(d));
			REG_MAX_Y:  max_y = longint'($signed(d));
			default: ;
		endcase
	endfunction

	function longint clip46(longint v);
		if (v > SAT_LIM) return SAT_LIM;
		if (v < -SAT_LIM) return -SAT_LIM;
		return v;
	endfunction

	function longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// signed Q16.16 product, truncated toward zero, saturated
	function longint qmul(longint a, longint b);
		longint unsigned ua, ub, hi, lo, r;
		bit neg;
		a = clip46(a);
		b = clip46(b);
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		hi = ua >> 16;
		lo = ua & FMASK;
		if (hi != 0 && ub > longint'(SAT_LIM) / hi)
			r = SAT_LIM;
		else begin
			r = hi * ub + lo * (ub >> 16) + ((lo * (ub & FMASK)) >> 16);
			if (r > SAT_LIM)
				r = SAT_LIM;
		end
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function longint unsigned uqmul(longint unsigned a, longint unsigned b);
		return (a >> 16) * b + (((a & FMASK) * b) >> 16);
	endfunction

	function longint dt_scale(longint a, longint unsigned ts);
		longint unsigned ua;
		a = clip46(a);
		ua = (a < 0) ? -a : a;
		ua = (ua * ts) >> 16;
		return (a < 0) ? -longint'(ua) : longint'(ua);
	endfunction

	function longint dz_pick(longint cam, longint tgt, longint half);
		longint d;
		d = tgt - cam;
		if (d > half) return tgt - half;
		if (d < -half) return tgt + half;
		return cam;
	endfunction

	function void damp(inout longint p, inout longint v, input longint des,
			input longint unsigned ts, input longint omega, input longint ex,
			input longint maxch);
		longint cur, change, base, tmp, nv, outp;
		cur = p;
		change = cur - des;
		if (speed != 0) begin
			if (change > maxch) change = maxch;
			if (change < -maxch) change = -maxch;
		end
		base = cur - change;
		tmp = dt_scale(clip46(v + qmul(omega, change)), ts);
		nv = qmul(clip46(v - qmul(omega, tmp)), ex);
		outp = base + qmul(clip46(change + tmp), ex);
		if ((des - cur > 0) == (outp > des)) begin
			outp = des;
			nv = 0;
		end
		p = clip32(outp);
		v = clip32(nv);
	endfunction

	function longint clamp_axis(longint p, longint lo, longint hi);
		if (lo <= hi) begin
			if (p < lo) return lo;
			if (p > hi) return hi;
		end
		return p;
	endfunction

	function void note(dsf_in_t r);
		longint unsigned ts, st, omega, x, x2, x3, den;
		longint dx, dy, ex, maxch;
		dsf_out_t o;
		ts = r.time_step;
		if (ts != 0) begin
			dx = dz_pick(px, longint'(r.target_x), dz_x);
			dy = dz_pick(py, longint'(r.target_y), dz_y);
			if (smooth == 0) begin
				px = dx; py = dy; vx = 0; vy = 0;
			end else begin
				st = (smooth < ST_MIN) ? ST_MIN : smooth;
				omega = (64'd2 << 32) / st;
				x = (omega * ts) >> 16;
				if (x > X_CAP)
					x = X_CAP;
				x2 = uqmul(x, x);
				x3 = uqmul(x2, x);
				den = 64'd65536 + x + uqmul(x2, K_048) + uqmul(x3, K_0235);
				ex = (64'd1 << 32) / den;
				maxch = (speed * st) >> 16;
				damp(px, vx, dx, ts, omega, ex, maxch);
				damp(py, vy, dy, ts, omega, ex, maxch);
			end
			px = clamp_axis(px, min_x, max_x);
			py = clamp_axis(py, min_y, max_y);
		end
		o.cam_x = px[31:0];
		o.cam_y = py[31:0];
		cam_expected.push_back(o);
	endfunction

	task report(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task check(dsf_out_t got);
		dsf_out_t e;
		if (cam_expected.size() == 0) begin
			report($sformatf("unexpected result %h", got));
			return;
		end
		e = cam_expected.pop_front();
		if (got.cam_x !== e.cam_x)
			report($sformatf("cam_x got %h want %h", got.cam_x, e.cam_x));
		if (got.cam_y !== e.cam_y)
			report($sformatf("cam_y got %h want %h", got.cam_y, e.cam_y));
	endtask
endclass

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the follower testbench: drives requests and register writes with random idling
// and checks every result against follow_board. Depends on dsf_pkg and follow_board.
module tb_top;
	import dsf_pkg::*;

	localparam int LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall, out_valid, out_stall, wr_en;
	dsf_in_t in_data;
	dsf_out_t out_data;
	logic [2:0] wr_index;
	logic [31:0] wr_data;

	int idle_pct, stall_pct, cycles;
	follow_board board;

	deadzone_smoothdamp_follow_2d uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check(out_data);

	task write_reg(logic [2:0] idx, logic [31:0] d);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = d;
		board.write_reg(idx, d);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task send(logic [31:0] tx, logic [31:0] ty, logic [15:0] ts);
		dsf_in_t r;
		r.target_x = tx;
		r.target_y = ty;
		r.time_step = ts;
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		in_data = r;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		board.note(r);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task drain();
		while (board.cam_expected.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function logic [31:0] pick_u31();
		case ($urandom_range(3))
			0: return 32'd0;
			1: return $urandom_range(1 << 20);
			2: return $urandom;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	task set_bounds(logic [2:0] lo_reg, logic [2:0] hi_reg);
		logic [31:0] a, b;
		case ($urandom_range(3))
			0: begin a = 32'd65536; b = 32'd0; end
			1: begin a = 32'h8000_0000; b = 32'h7FFF_FFFF; end
			2: begin a = $urandom; b = a; end
			default: begin
				a = $urandom_range(1 << 22) - (1 << 21);
				b = a + $urandom_range(1 << 22);
			end
		endcase
		write_reg(lo_reg, a);
		write_reg(hi_reg, b);
	endtask

	task random_config();
		logic [31:0] st;
		case ($urandom_range(5))
			0: st = 32'd0;
			1: st = $urandom_range(1, 6);
			2: st = 32'h7FFF_FFFF;
			3: st = $urandom;
			default: st = $urandom_range(7, 200000);
		endcase
		write_reg(REG_DZ_X, pick_u31());
		write_reg(REG_DZ_Y, pick_u31());
		write_reg(REG_SMOOTH, st);
		write_reg(REG_SPEED, pick_u31());
		set_bounds(REG_MIN_X, REG_MAX_X);
		set_bounds(REG_MIN_Y, REG_MAX_Y);
	endtask

	function logic [31:0] pick_target(logic [31:0] near);
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return near + $urandom_range(1 << 21) - (1 << 20);
		endcase
	endfunction

	function logic [15:0] pick_step();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return $urandom_range(1, 64);
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	initial begin
		board = new();
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_DZ_X;
		wr_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset defaults, extremes, zero step
		send(32'h0001_0000, 32'hFFFF_0000, 16'd1000);
		send(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
		send(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
		send(32'h1234_5678, 32'h8765_4321, 16'd0);
		send(32'd0, 32'd0, 16'hFFFF);
		send(32'h0010_0000, 32'h0010_0000, 16'd3000);
		drain();
		// snap with bounds, deadzone
		write_reg(REG_SMOOTH, 32'd0);
		write_reg(REG_DZ_X, 32'h0002_0000);
		write_reg(REG_DZ_Y, 32'hFFFF_FFFF);
		write_reg(REG_MIN_X, 32'hFFF0_0000);
		write_reg(REG_MAX_X, 32'h0010_0000);
		write_reg(REG_MIN_Y, 32'h0000_1000);
		write_reg(REG_MAX_Y, 32'h0000_1000);
		send(32'h0100_0000, 32'h0100_0000, 16'd10);
		send(32'h8000_0000, 32'h8000_0000, 16'd10);
		send(32'h0000_1000, 32'hFFFF_0000, 16'd0);
		drain();
		// speed limit, tiny smooth time, overshoot-prone steps
		write_reg(REG_SMOOTH, 32'd3);
		write_reg(REG_SPEED, 32'h0001_0000);
		write_reg(REG_MIN_X, 32'd65536);
		write_reg(REG_MAX_X, 32'd0);
		send(32'h0050_0000, 32'h0000_0000, 16'hFFFF);
		send(32'hFFB0_0000, 32'h0020_0000, 16'd500);
		drain();
		write_reg(REG_SPEED, 32'h7FFF_FFFF);
		write_reg(REG_SMOOTH, 32'h7FFF_FFFF);
		send(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
		send(32'h0000_0000, 32'h0000_0000, 16'd1);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 34 : (ph == 1) ? 65 : 0;
			stall_pct = (ph == 0) ? 65 : (ph == 1) ? 34 : 0;
			for (int chunk = 0; chunk < 6; chunk++) begin
				drain();
				random_config();
				for (int i = 0; i < 93; i++)
					send(pick_target(board.px[31:0]), pick_target(board.py[31:0]),
						pick_step());
			end
		end

		while (board.cam_expected.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
